[hdl/tbdc_pkg.sv]
// Shared types and constants of the two-beam direction counter.
`default_nettype none
package tbdc_pkg;

	localparam int TIME_W  = 32;
	localparam int LEVEL_W = 12;
	localparam int COUNT_W = 8;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	localparam logic [LEVEL_W-1:0] THRESHOLD_RST = 12'd2270;
	localparam logic [TIME_W-1:0]  DEBOUNCE_RST  = 32'd100000;
	localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
	localparam logic [COUNT_W-1:0] COUNT_MIN     = '0;

	localparam int QUEUE_DEPTH_DEF = 2;

	// register index, taken from paddr[2]
	typedef enum logic {
		REG_RELEASE_THRESHOLD = 1'b0,
		REG_DEBOUNCE_US       = 1'b1
	} reg_idx_t;

	// recognizer progress flags
	typedef logic [2:0] progress_t;
	localparam progress_t STEP1     = 3'b001;
	localparam progress_t STEP2     = 3'b010;
	localparam progress_t STEP3     = 3'b100;
	localparam progress_t ALL_STEPS = 3'b111;

	// classified event passed from front to back
	typedef struct packed {
		logic accepted;
		logic inner;
		logic is_release;
	} event_t;

endpackage
`default_nettype wire

[hdl/tbdc_ifs.sv]
// Valid/ready channel interfaces for edge events and count results.
`default_nettype none
interface tbdc_in_if;
	import tbdc_pkg::*;
	logic               valid;
	logic               ready;
	logic               beam_sel;
	logic [TIME_W-1:0]  time_us;
	logic [LEVEL_W-1:0] beam_level;
	modport source (output valid, beam_sel, time_us, beam_level, input ready);
	modport sink (input valid, beam_sel, time_us, beam_level, output ready);
endinterface

interface tbdc_out_if;
	import tbdc_pkg::*;
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] occupancy;
	logic               accepted;
	logic               entered;
	logic               exited;
	modport source (output valid, occupancy, accepted, entered, exited, input ready);
	modport sink (input valid, occupancy, accepted, entered, exited, output ready);
endinterface
`default_nettype wire

[hdl/tbdc_front.sv]
// Front end: debounce per beam and break/release classification.
`default_nettype none
module tbdc_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	tbdc_in_if.sink                           item,
	input  wire logic [tbdc_pkg::LEVEL_W-1:0] threshold,
	input  wire logic [tbdc_pkg::TIME_W-1:0]  debounce,
	input  wire logic                         full,
	output      logic                         push,
	output      tbdc_pkg::event_t             ev
);
	import tbdc_pkg::*;

	logic [TIME_W-1:0] outer_last_q;
	logic [TIME_W-1:0] inner_last_q;
	logic [TIME_W-1:0] last_time;
	logic [TIME_W-1:0] elapsed;
	logic              pass;

	assign item.ready = !full;
	assign push       = item.valid && !full;

	assign last_time = item.beam_sel ? inner_last_q : outer_last_q;
	assign elapsed   = item.time_us - last_time;   // wraps mod 2^32
	assign pass      = elapsed > debounce;

	assign ev.accepted   = pass;
	assign ev.inner      = item.beam_sel;
	assign ev.is_release = item.beam_level > threshold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outer_last_q <= '0;
			inner_last_q <= '0;
		end else if (push && pass) begin
			if (item.beam_sel) begin
				inner_last_q <= item.time_us;
			end else begin
				outer_last_q <= item.time_us;
			end
		end
	end

endmodule
`default_nettype wire

[hdl/tbdc_queue.sv]
// Small event queue between front and back.
`default_nettype none
module tbdc_queue #(
	parameter int DEPTH = tbdc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire tbdc_pkg::event_t wdata,
	output      logic             full,
	input  wire logic             pop,
	output      tbdc_pkg::event_t rdata,
	output      logic             empty
);
	import tbdc_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

	event_t          mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign full  = cnt_q == CW'(DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty)) else $error("queue pop while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH)) else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

[hdl/tbdc_back.sv]
// Back end: entry/exit recognizers, occupancy count and result register.
`default_nettype none
module tbdc_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             empty,
	input  wire tbdc_pkg::event_t ev,
	output      logic             pop,
	tbdc_out_if.source            result
);
	import tbdc_pkg::*;

	// returns {done, next progress}
	function automatic logic [3:0] advance(progress_t p, logic on_first, logic rel);
		progress_t n;
		logic      done;
		n    = p;
		done = 1'b0;
		if (!rel && on_first) begin
			n = p | STEP1;
		end else if (!rel) begin
			n = ((p & STEP1) != '0) ? (p | STEP2) : '0;
		end else if (on_first) begin
			n = ((p & (STEP1 | STEP2)) == (STEP1 | STEP2)) ? (p | STEP3) : '0;
		end else begin
			done = p == ALL_STEPS;
			n    = '0;
		end
		return {done, n};
	endfunction

	progress_t          entry_q;
	progress_t          exit_q;
	logic [COUNT_W-1:0] count_q;
	logic               valid_q;
	logic [COUNT_W-1:0] occ_q;
	logic               acc_q;
	logic               ent_q;
	logic               ext_q;

	logic [3:0]         entry_adv;
	logic [3:0]         exit_adv;
	logic               ent;
	logic               ext;
	logic [COUNT_W-1:0] count_nxt;

	assign pop = !empty && (!valid_q || result.ready);

	assign entry_adv = advance(entry_q, !ev.inner, ev.is_release);
	assign exit_adv  = advance(exit_q, ev.inner, ev.is_release);
	assign ent       = ev.accepted && entry_adv[3];
	assign ext       = ev.accepted && exit_adv[3];

	always_comb begin
		count_nxt = count_q;
		if (ent && count_q != COUNT_MAX) begin
			count_nxt = count_q + 1'b1;
		end else if (ext && count_q != COUNT_MIN) begin
			count_nxt = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
			exit_q  <= '0;
			count_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
				if (ev.accepted) begin
					entry_q <= entry_adv[2:0];
					exit_q  <= exit_adv[2:0];
					count_q <= count_nxt;
				end
			end else if (result.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			occ_q <= count_nxt;
			acc_q <= ev.accepted;
			ent_q <= ent;
			ext_q <= ext;
		end
	end

	assign result.valid     = valid_q;
	assign result.occupancy = occ_q;
	assign result.accepted  = acc_q;
	assign result.entered   = ent_q;
	assign result.exited    = ext_q;

`ifndef SYNTHESIS
	a_rejected_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !ev.accepted |=> count_q == $past(count_q) && entry_q == $past(entry_q)
			&& exit_q == $past(exit_q)) else $error("rejected event changed state");
	a_not_both: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> !(ent_q && ext_q)) else $error("entry and exit on one event");
	a_entry_count: assert property (@(posedge clk) disable iff (!arst_n)
		pop && ent |=> count_q == COUNT_MAX || count_q == $past(count_q) + 1'b1)
		else $error("entry did not raise count");
	a_occ_matches: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> occ_q == count_q) else $error("result occupancy differs from count");
`endif

endmodule
`default_nettype wire

[hdl/two_beam_direction_counter.sv]
// Top level of the two-beam direction counter: APB registers, front, queue, back.
//
//  channel   dir  handshake          payload
//  item      in   valid/ready        beam_sel, time_us[31:0], beam_level[11:0]
//  result    out  valid/ready        occupancy[7:0], accepted, entered, exited
//  apb       in   psel/penable       paddr[2:0], pwdata[31:0], prdata[31:0]
//
// One item per cycle sustained while result.ready stays high; a transfer is written into
// the queue, and the result register loads from the queue head when it is free or taken.
// The back end's recognizer and count update is combinational, which sets the rate.
// The queue (QUEUE_DEPTH entries) plus the result register absorb a result-side stall;
// item.ready drops only when the queue is full.
// arst_n clears timestamps, recognizers, count and queue; registers go to their defaults.
`default_nettype none
module two_beam_direction_counter #(
	parameter int QUEUE_DEPTH = tbdc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	tbdc_in_if.sink                              item,
	tbdc_out_if.source                           result,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [tbdc_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [tbdc_pkg::APB_DATA_W-1:0] pwdata,
	output      logic [tbdc_pkg::APB_DATA_W-1:0] prdata,
	output      logic                            pready
);
	import tbdc_pkg::*;

	logic [LEVEL_W-1:0] threshold_q;
	logic [TIME_W-1:0]  debounce_q;
	reg_idx_t           reg_idx;
	logic               wr_en;

	logic               push;
	logic               pop;
	logic               full;
	logic               empty;
	event_t             ev_in;
	event_t             ev_out;

	// registers are word addressed; paddr[2] picks the register
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			debounce_q  <= DEBOUNCE_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_RELEASE_THRESHOLD: threshold_q <= pwdata[LEVEL_W-1:0];
				REG_DEBOUNCE_US:       debounce_q  <= pwdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_RELEASE_THRESHOLD: prdata = APB_DATA_W'(threshold_q);
			REG_DEBOUNCE_US:       prdata = APB_DATA_W'(debounce_q);
			default:               prdata = '0;
		endcase
	end

	// front: debounce and classify every transfer, rejected ones included
	tbdc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.threshold (threshold_q),
		.debounce  (debounce_q),
		.full      (full),
		.push      (push),
		.ev        (ev_in)
	);

	// decoupling queue
	tbdc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (ev_in),
		.full   (full),
		.pop    (pop),
		.rdata  (ev_out),
		.empty  (empty)
	);

	// back: recognizers, count and result register
	tbdc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.ev     (ev_out),
		.pop    (pop),
		.result (result)
	);

endmodule
`default_nettype wire
